// ===== hw/rtl/cfbc_pkg.sv =====
`default_nettype none

package cfbc_pkg;

	// Frame geometry: 74 bytes sent as 37 byte pairs.
	localparam int PAIR_COUNT = 37;
	localparam logic [5:0] PAIR_LAST = 6'(PAIR_COUNT - 1);

	// Pair positions that carry something other than zero.
	localparam logic [5:0] PAIR_SEQ     = 6'd0;
	localparam logic [5:0] PAIR_FIELDS  = 6'd1;
	localparam logic [5:0] PAIR_STATION = 6'd2;
	localparam logic [5:0] PAIR_VER0    = 6'd9;
	localparam logic [5:0] PAIR_VER1    = 6'd10;
	localparam logic [5:0] PAIR_VER2    = 6'd11;
	localparam logic [5:0] PAIR_VER3    = 6'd12;
	localparam logic [5:0] PAIR_CRC_HI  = 6'd35;
	localparam logic [5:0] PAIR_CRC_LO  = 6'd36;

	// Version digits, two per pair.
	localparam logic [15:0] VER_PAIR0 = {8'd0, 8'd6};
	localparam logic [15:0] VER_PAIR1 = {8'd2, 8'd5};
	localparam logic [15:0] VER_PAIR2 = {8'd0, 8'd8};
	localparam logic [15:0] VER_PAIR3 = {8'd4, 8'd6};

	// Reflected CRC-32 constants.
	localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
	localparam logic [31:0] CRC_XOROUT = 32'hFFFF_FFFF;

	// Everything needed to produce one frame.
	typedef struct packed {
		logic [7:0]  seq_low;
		logic [7:0]  seq_high;
		logic [7:0]  robot_state;
		logic [7:0]  alliance;
		logic [7:0]  station_number;
		logic [31:0] crc;
	} frame_rec_t;

	// Content of one byte pair of the frame, earlier byte in the upper half.
	function automatic logic [15:0] pair_bytes(frame_rec_t rec, logic [5:0] idx);
		logic [15:0] r;
		case (idx)
			PAIR_SEQ:     r = {rec.seq_low, rec.seq_high};
			PAIR_FIELDS:  r = {rec.robot_state, rec.alliance};
			PAIR_STATION: r = {rec.station_number, 8'h00};
			PAIR_VER0:    r = VER_PAIR0;
			PAIR_VER1:    r = VER_PAIR1;
			PAIR_VER2:    r = VER_PAIR2;
			PAIR_VER3:    r = VER_PAIR3;
			PAIR_CRC_HI:  r = rec.crc[31:16];
			PAIR_CRC_LO:  r = rec.crc[15:0];
			default:      r = 16'h0000;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cfbc_front.sv =====
`default_nettype none

module cfbc_front import cfbc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] robot_state,
	input  wire logic [7:0] alliance,
	input  wire logic [7:0] station_number,
	output logic            q_push,
	output frame_rec_t      q_data,
	input  wire logic       q_full
);

	// One byte through the reflected CRC, one bit per step.
	function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'h000000, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	logic       busy_q;
	logic [5:0] cnt_q;
	logic [7:0] seq_low_q;
	logic [7:0] seq_high_q;
	logic [31:0] crc_q;
	frame_rec_t rec_q;
	frame_rec_t rec_zero;
	logic [15:0] pair_w;
	logic [31:0] crc_next;
	logic       done;
	logic       push_ok;
	logic       accept;

	// The CRC sees the frame with its CRC bytes still zero.
	always_comb begin
		rec_zero = rec_q;
		rec_zero.crc = '0;
		pair_w = pair_bytes(rec_zero, cnt_q);
		crc_next = crc_byte(crc_byte(crc_q, pair_w[15:8]), pair_w[7:0]);
	end

	// The last pair step hands the finished record to the queue.
	assign done    = busy_q && (cnt_q == PAIR_LAST);
	assign push_ok = done && !q_full;
	assign full    = busy_q && !push_ok;
	assign accept  = push && !full;

	assign q_push = push_ok;
	always_comb begin
		q_data = rec_q;
		q_data.crc = crc_next ^ CRC_XOROUT;
	end

	// Control state and the sequence counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			cnt_q      <= '0;
			seq_low_q  <= '0;
			seq_high_q <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				if (seq_high_q == 8'h00) begin
					if (seq_low_q == 8'hFF) begin
						seq_low_q  <= 8'h00;
						seq_high_q <= 8'h01;
					end else begin
						seq_low_q <= seq_low_q + 8'h01;
					end
				end else if (seq_high_q == 8'hFF) begin
					seq_low_q  <= 8'h00;
					seq_high_q <= 8'h00;
				end else begin
					seq_high_q <= seq_high_q + 8'h01;
				end
			end else if (push_ok) begin
				busy_q <= 1'b0;
			end else if (busy_q && !done) begin
				cnt_q <= cnt_q + 6'd1;
			end
		end
	end

	// Request fields and the running CRC.
	always_ff @(posedge clk) begin
		if (accept) begin
			rec_q.seq_low        <= seq_low_q;
			rec_q.seq_high       <= seq_high_q;
			rec_q.robot_state    <= robot_state;
			rec_q.alliance       <= alliance;
			rec_q.station_number <= station_number;
			rec_q.crc            <= '0;
			crc_q                <= CRC_INIT;
		end else if (busy_q && !done) begin
			crc_q <= crc_next;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/cfbc_queue.sv =====
`default_nettype none

module cfbc_queue import cfbc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       wr_en,
	input  wire frame_rec_t wr_data,
	output logic            q_full,
	input  wire logic       rd_en,
	output frame_rec_t      rd_data,
	output logic            q_empty
);

	frame_rec_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_wr;
	logic       do_rd;

	assign q_full  = (count_q == 2'd2);
	assign q_empty = (count_q == 2'd0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = entry_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/cfbc_back.sv =====
`default_nettype none

module cfbc_back import cfbc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_empty,
	input  wire frame_rec_t q_head,
	output logic            q_pop,
	output logic            empty,
	input  wire logic       pop,
	output logic [15:0]     pair_data,
	output logic [5:0]      pair_index,
	output logic            last
);

	logic [5:0] k_q;
	logic       out_valid_q;
	logic       load;

	// A new pair enters the output register when it is free or being emptied.
	assign load  = (!out_valid_q || pop) && !q_empty;
	assign q_pop = load && (k_q == PAIR_LAST);
	assign empty = !out_valid_q;

	// Pair counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				k_q <= (k_q == PAIR_LAST) ? 6'd0 : k_q + 6'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load) begin
			pair_data  <= pair_bytes(q_head, k_q);
			pair_index <= k_q;
			last       <= (k_q == PAIR_LAST);
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/control_frame_builder_crc32.sv =====
// Flow: the front runs the CRC over all 37 pairs and writes the record into the queue;
// the back loads the first pair; the other 36 follow one per cycle while pop is held.
// Throughput: the front takes no new request until it hands the last record to the queue;
// the CRC takes two bytes per cycle; the port moves one pair per cycle while pop is held.
// Reset: arst_n clears the sequence counter, the queue and all valid flags at once.
`default_nettype none

module control_frame_builder_crc32 import cfbc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  robot_state,
	input  wire logic [7:0]  alliance,
	input  wire logic [7:0]  station_number,
	output logic             empty,
	input  wire logic        pop,
	output logic [15:0]      pair_data,
	output logic [5:0]       pair_index,
	output logic             last
);

	logic       fq_push;
	frame_rec_t fq_wdata;
	logic       fq_full;
	logic       fq_pop;
	frame_rec_t fq_head;
	logic       fq_empty;

	// Front: sequence numbering and CRC over the frame.
	cfbc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.robot_state    (robot_state),
		.alliance       (alliance),
		.station_number (station_number),
		.q_push         (fq_push),
		.q_data         (fq_wdata),
		.q_full         (fq_full)
	);

	// Queue of finished frame records.
	cfbc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fq_push),
		.wr_data (fq_wdata),
		.q_full  (fq_full),
		.rd_en   (fq_pop),
		.rd_data (fq_head),
		.q_empty (fq_empty)
	);

	// Back: sends each frame as 37 pairs.
	cfbc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (fq_empty),
		.q_head     (fq_head),
		.q_pop      (fq_pop),
		.empty      (empty),
		.pop        (pop),
		.pair_data  (pair_data),
		.pair_index (pair_index),
		.last       (last)
	);

endmodule

`default_nettype wire
